@@ sv/twbs_pkg.sv @@
// Package for the texture wrap bilinear sampler.
// Holds field widths, wrap mode codes and configuration register indexes.
// No dependencies.
package twbs_pkg;
  localparam int DefMaxSide = 64;
  localparam int CoordW = 17;
  localparam int IdxW = 10;   // signed texel index before wrapping
  localparam int SideW = 6;   // wrapped texel index
  localparam int FracW = 9;   // fraction expanded to 0..256
  localparam int WeightW = 17;
  localparam int AccW = 25;

  localparam logic [1:0] WrapClamp = 2'd0;
  localparam logic [1:0] WrapRepeat = 2'd1;
  localparam logic [1:0] WrapMirror = 2'd2;

  localparam logic [2:0] RegWrapS = 3'd0;
  localparam logic [2:0] RegWrapT = 3'd1;
  localparam logic [2:0] RegMinFilter = 3'd2;
  localparam logic [2:0] RegMagFilter = 3'd3;
  localparam logic [2:0] RegWidthM1 = 3'd4;
  localparam logic [2:0] RegHeightM1 = 3'd5;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [1:0]      mode;
    logic [SideW-1:0] last;
  } wrap_req_t;
endpackage

@@ sv/texture_wrap_bilinear_sampler.sv @@
// Top level of the texture wrap bilinear sampler.
// Holds the texel memory, the sample sequencer and the blend; uses twbs_wrap.
// Depends on twbs_pkg.
//
// A write word (tuser 0) stores one texel in the single-port texel memory. A
// sample word (tuser 1) goes through these steps before its result is offered:
// the four texel indexes pass one after another through the shared wrap unit
// and its serial divider, and then the four texels are read from the one
// memory port while the weighted channel sums are built, and a last step loads
// the result. Nearest sampling runs the same sequence with all weight on the
// first texel. A new word is accepted while the previous result still waits.
module texture_wrap_bilinear_sampler import twbs_pkg::*; #(
  parameter int MAX_SIDE = DefMaxSide
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // coord_s[16:0], coord_t[33:17], lod_positive[34], write_x[40:35],
  // write_y[46:41], write_texel[78:47], zero[79]
  input  logic [79:0] s_axis_tdata,
  // action[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte0[7:0], out_byte1[15:8], out_byte2[23:16], out_byte3[31:24]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  localparam int Depth = MAX_SIDE * MAX_SIDE;
  localparam int AddrW = $clog2(Depth);
  localparam logic [AddrW-1:0] SideA = AddrW'(MAX_SIDE);
  localparam logic [WeightW-1:0] FracOne = WeightW'(256);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWrap = 2'd1;
  localparam logic [1:0] StRead = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0] wrap_s_q, wrap_t_q, mag_unused;
  logic [2:0] min_q;
  logic       mag_q;
  logic [SideW-1:0] wm1_q, hm1_q;

  assign cfg_ready_o = 1'b1;
  assign mag_unused = '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_s_q <= '0;
      wrap_t_q <= '0;
      min_q    <= '0;
      mag_q    <= 1'b0;
      wm1_q    <= '1;
      hm1_q    <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegWrapS:     wrap_s_q <= cfg_data_i[1:0];
        RegWrapT:     wrap_t_q <= cfg_data_i[1:0];
        RegMinFilter: min_q    <= cfg_data_i[2:0];
        RegMagFilter: mag_q    <= cfg_data_i[0];
        RegWidthM1:   wm1_q    <= cfg_data_i[SideW-1:0];
        RegHeightM1:  hm1_q    <= cfg_data_i[SideW-1:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [CoordW-1:0] cs, ct;
  logic              lod, action;
  logic [SideW-1:0]  wx, wy;
  logic [31:0]       wtexel;
  assign cs     = s_axis_tdata[16:0];
  assign ct     = s_axis_tdata[33:17];
  assign lod    = s_axis_tdata[34];
  assign wx     = s_axis_tdata[40:35];
  assign wy     = s_axis_tdata[46:41];
  assign wtexel = s_axis_tdata[78:47];
  assign action = s_axis_tuser[0];

  logic [1:0] state_q;
  logic       in_acc;
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Index and fraction split of one coordinate.
  function automatic logic [IdxW+FracW-1:0] split(input logic [CoordW-1:0] c,
                                                  input logic lin);
    logic [CoordW:0]   v;
    logic [IdxW-1:0]   n;
    logic [FracW-1:0]  f;
    v = {c[CoordW-1], c} - (CoordW+1)'(128);
    if (lin) begin
      f = {1'b0, v[7:0]} + FracW'(v[7]);
      return {v[CoordW:8], f};
    end
    n = {c[CoordW-1], c[CoordW-1:8]} + IdxW'(c[CoordW-1] && (c[7:0] != 8'd0));
    return {n, {FracW{1'b0}}};
  endfunction

  logic linear;
  logic [IdxW+FracW-1:0] sp_s, sp_t;
  assign linear = lod ? (min_q > 3'd4) : mag_q;
  assign sp_s = split(cs, linear);
  assign sp_t = split(ct, linear);

  logic [IdxW-1:0]   s0_q, t0_q;
  logic [FracW-1:0]  fs_q, ft_q;
  logic [1:0]        wk_q;
  logic              start_q;
  logic [SideW-1:0]  res_q [4];
  logic [WeightW-1:0] w_q [4];
  logic [2:0]        rk_q;
  logic [AccW-1:0]   acc_q [4];
  logic              rvalid_q;
  logic [31:0]       rdata_q;
  logic [31:0]       out_q;
  logic              ovalid_q;

  wrap_req_t        wreq;
  logic             wdone;
  logic [SideW-1:0] wres;

  always_comb begin
    case (wk_q)
      2'd0:    wreq = '{idx: s0_q, mode: wrap_s_q, last: wm1_q};
      2'd1:    wreq = '{idx: s0_q + 1'b1, mode: wrap_s_q, last: wm1_q};
      2'd2:    wreq = '{idx: t0_q, mode: wrap_t_q, last: hm1_q};
      default: wreq = '{idx: t0_q + 1'b1, mode: wrap_t_q, last: hm1_q};
    endcase
  end

  twbs_wrap u_wrap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_q),
    .req_i    (wreq),
    .done_o   (wdone),
    .result_o (wres)
  );

  // Read address for texel pair rk: S from bit 0, T from bit 1.
  logic [SideW-1:0] rx, ry;
  logic             rin;
  logic [AddrW-1:0] raddr, waddr;
  assign rx = rk_q[0] ? res_q[1] : res_q[0];
  assign ry = rk_q[1] ? res_q[3] : res_q[2];
  assign rin = (32'(rx) < MAX_SIDE) && (32'(ry) < MAX_SIDE);
  assign raddr = AddrW'(ry) * SideA + AddrW'(rx);
  assign waddr = AddrW'(wy) * SideA + AddrW'(wx);

  logic [31:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (in_acc && !action && (32'(wx) < MAX_SIDE) && (32'(wy) < MAX_SIDE)) begin
      mem_q[waddr] <= wtexel;
    end
    if (state_q == StRead && rk_q < 3'd4) begin
      rdata_q <= mem_q[raddr];
    end
  end

  logic [31:0] texel;
  assign texel = rvalid_q ? rdata_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      wk_q     <= '0;
      rk_q     <= '0;
      start_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      start_q <= (in_acc && action) || (state_q == StWrap && wdone && wk_q != 2'd3);
      if (state_q == StFin && (!ovalid_q || m_axis_tready)) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc && action) begin
            state_q <= StWrap;
            wk_q    <= '0;
          end
        end
        StWrap: begin
          if (wdone) begin
            if (wk_q == 2'd3) begin
              state_q <= StRead;
              rk_q    <= '0;
            end else begin
              wk_q    <= wk_q + 1'b1;
            end
          end
        end
        StRead: begin
          rk_q <= rk_q + 1'b1;
          if (rk_q == 3'd4) begin
            state_q <= StFin;
          end
        end
        StFin: begin
          if (!ovalid_q || m_axis_tready) begin
            state_q  <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && action) begin
      s0_q <= sp_s[IdxW+FracW-1:FracW];
      fs_q <= sp_s[FracW-1:0];
      t0_q <= sp_t[IdxW+FracW-1:FracW];
      ft_q <= sp_t[FracW-1:0];
    end
    if (state_q == StWrap) begin
      w_q[0] <= (FracOne - WeightW'(fs_q)) * (FracOne - WeightW'(ft_q));
      w_q[1] <= WeightW'(fs_q) * (FracOne - WeightW'(ft_q));
      w_q[2] <= (FracOne - WeightW'(fs_q)) * WeightW'(ft_q);
      w_q[3] <= WeightW'(fs_q) * WeightW'(ft_q);
      if (wdone) begin
        res_q[wk_q] <= wres;
      end
      for (int i = 0; i < 4; i++) begin
        acc_q[i] <= '0;
      end
    end
    if (state_q == StRead) begin
      // A texel with no weight is not used, so its memory word is not needed.
      rvalid_q <= rin && (w_q[rk_q[1:0]] != '0);
      if (rk_q != 3'd0) begin
        for (int i = 0; i < 4; i++) begin
          acc_q[i] <= acc_q[i] + AccW'(texel[8*i +: 8]) * AccW'(w_q[rk_q[1:0] - 2'd1]);
        end
      end
    end
    if (state_q == StFin && (!ovalid_q || m_axis_tready)) begin
      for (int i = 0; i < 4; i++) begin
        out_q[8*i +: 8] <= acc_q[i][23:16] | {6'd0, mag_unused};
      end
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  a_wrap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wdone |-> (wres <= wreq.last))
    else $error("wrapped index beyond the largest index");
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == StFin))
    else $error("result word raised outside the finish step");
  a_read_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> (rk_q <= 3'd4))
    else $error("read counter overran");
endmodule

@@ sv/twbs_wrap.sv @@
// Wrap unit: maps a signed texel index into 0..last by clamp, repeat or mirror.
// Repeat and mirror use a restoring divider, one quotient bit per cycle.
// Depends on twbs_pkg.
module twbs_wrap import twbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  wrap_req_t        req_i,
  output logic             done_o,
  output logic [SideW-1:0] result_o
);
  localparam int MagW = IdxW - 1;

  logic             busy_q, done_q, neg_q, qbit_q;
  logic [3:0]       cnt_q;
  logic [MagW-1:0]  mag_q;
  logic [SideW:0]   rem_q;
  logic [1:0]       mode_q;
  logic [SideW-1:0] last_q, clamp_q;
  logic [SideW:0]   span;
  logic [SideW+1:0] trial;
  logic [IdxW-1:0]  absval;
  logic [SideW-1:0] clamp_d;

  assign span = {1'b0, last_q} + 1'b1;
  assign trial = {rem_q, mag_q[MagW-1]};
  assign absval = req_i.idx[IdxW-1] ? (~req_i.idx + 1'b1) : req_i.idx;

  always_comb begin
    if ($signed(req_i.idx) > $signed({{(IdxW-SideW){1'b0}}, req_i.last})) begin
      clamp_d = req_i.last;
    end else if (req_i.idx[IdxW-1]) begin
      clamp_d = '0;
    end else begin
      clamp_d = req_i.idx[SideW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == 4'(MagW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 4'(MagW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q   <= absval[MagW-1:0];
      rem_q   <= '0;
      neg_q   <= req_i.idx[IdxW-1];
      mode_q  <= req_i.mode;
      last_q  <= req_i.last;
      clamp_q <= clamp_d;
      qbit_q  <= 1'b0;
    end else if (busy_q) begin
      mag_q <= {mag_q[MagW-2:0], 1'b0};
      if (trial >= {1'b0, span}) begin
        rem_q  <= (SideW+1)'(trial - {1'b0, span});
        qbit_q <= 1'b1;
      end else begin
        rem_q  <= trial[SideW:0];
        qbit_q <= 1'b0;
      end
    end
  end

  always_comb begin
    case (mode_q)
      WrapRepeat: result_o = (neg_q && rem_q != '0) ? SideW'(span - rem_q)
                                                    : rem_q[SideW-1:0];
      WrapMirror: result_o = qbit_q ? SideW'({1'b0, last_q} - rem_q)
                                    : rem_q[SideW-1:0];
      default:    result_o = clamp_q;
    endcase
  end

  assign done_o = done_q;
endmodule

@@ tb/sv/twbs_checker.sv @@
// Checker for the texture wrap bilinear sampler: watches the input, output and
// configuration channels, predicts every sampled texel and compares it.
// Depends on twbs_pkg.
module twbs_checker import twbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] texels [DefMaxSide*DefMaxSide];
  logic [1:0]  wrap_s, wrap_t;
  logic [2:0]  min_f;
  logic        mag_f;
  logic [5:0]  last_s, last_t;
  logic [31:0] texel_queue [$];

  function automatic int wrap_coord(int idx, logic [1:0] mode, int last);
    int span, q, r;
    span = last + 1;
    if (mode == WrapRepeat) begin
      r = idx % span;
      return (r < 0) ? span + r : r;
    end
    if (mode == WrapMirror) begin
      q = idx / span;
      r = idx - q * span;
      if (r < 0) r = -r;
      if (q[0]) r = last - r;
      return r;
    end
    if (idx > last) return last;
    if (idx < 0) return 0;
    return idx;
  endfunction

  function automatic logic [31:0] read_texel(int x, int y);
    return texels[y * DefMaxSide + x];
  endfunction

  function automatic logic [31:0] sample_texel(logic [79:0] d);
    int cs, ct, s0, t0, s1, t1, fs, ft, u;
    logic [31:0] acc [4];
    logic [31:0] tx [4];
    int wt [4];
    logic linear;
    logic [31:0] res;
    cs = $signed(d[16:0]);
    ct = $signed(d[33:17]);
    linear = d[34] ? (min_f > 3'd4) : mag_f;
    if (!linear) return read_texel(wrap_coord(cs / 256, wrap_s, last_s),
                                   wrap_coord(ct / 256, wrap_t, last_t));
    u = cs - 128 + 65792;
    s0 = (u >>> 8) - 257;
    fs = (u & 255) + ((u & 255) >> 7);
    u = ct - 128 + 65792;
    t0 = (u >>> 8) - 257;
    ft = (u & 255) + ((u & 255) >> 7);
    s1 = wrap_coord(s0 + 1, wrap_s, last_s);
    t1 = wrap_coord(t0 + 1, wrap_t, last_t);
    s0 = wrap_coord(s0, wrap_s, last_s);
    t0 = wrap_coord(t0, wrap_t, last_t);
    tx[0] = read_texel(s0, t0); wt[0] = (256 - fs) * (256 - ft);
    tx[1] = read_texel(s1, t0); wt[1] = fs * (256 - ft);
    tx[2] = read_texel(s0, t1); wt[2] = (256 - fs) * ft;
    tx[3] = read_texel(s1, t1); wt[3] = fs * ft;
    for (int c = 0; c < 4; c++) begin
      acc[c] = '0;
      for (int k = 0; k < 4; k++) acc[c] += tx[k][8*c +: 8] * wt[k];
      res[8*c +: 8] = acc[c][23:16];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      wrap_s = WrapClamp; wrap_t = WrapClamp;
      min_f = 3'd0; mag_f = 1'b0; last_s = 6'd63; last_t = 6'd63;
      fail_count_o = 0;
      pending_o = 0;
      texel_queue.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegWrapS:     wrap_s = cfg_data_i[1:0];
          RegWrapT:     wrap_t = cfg_data_i[1:0];
          RegMinFilter: min_f = cfg_data_i[2:0];
          RegMagFilter: mag_f = cfg_data_i[0];
          RegWidthM1:   last_s = cfg_data_i[5:0];
          RegHeightM1:  last_t = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0])
          texel_queue.push_back(sample_texel(s_axis_tdata));
        else
          texels[s_axis_tdata[46:41] * DefMaxSide + s_axis_tdata[40:35]] =
            s_axis_tdata[78:47];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (texel_queue.size() == 0) begin
          $error("unexpected word: m_axis_tdata %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = texel_queue.pop_front();
          for (int c = 0; c < 4; c++)
            if (want[8*c +: 8] !== m_axis_tdata[8*c +: 8]) begin
              $error("out_byte%0d: expected %h, actual %h", c, want[8*c +: 8],
                     m_axis_tdata[8*c +: 8]);
              fail_count_o++;
            end
        end
      end
      pending_o = texel_queue.size();
    end
  end
endmodule

@@ tb/sv/tb.sv @@
// Top of the testbench for the texture wrap bilinear sampler: clock, reset,
// stimulus and verdict. Depends on twbs_pkg, twbs_checker and the block.
module tb import twbs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = 0;
  logic [0:0]  s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = 0;
  logic [7:0]  cfg_data_i = 0;
  int          fail_count, pending, idle_cycles;
  int          sent = 0;
  bit          stall_hold = 0;
  logic [5:0]  cur_w = 6'd63, cur_h = 6'd63;
  bit          written [64][64];

  always #6 clk_i = ~clk_i;

  texture_wrap_bilinear_sampler dut (.*);

  twbs_checker u_checker (.*, .fail_count_o(fail_count), .pending_o(pending));

  // Hold-off rule on the result side; a long hold is requested by the stimulus.
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_hold) begin
        m_axis_tready <= 0;
        repeat (400) @(negedge clk_i);
        stall_hold = 0;
      end else if ($urandom_range(0, 9) < 3) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(0, 19) < 18 ? $urandom_range(1, 3)
                                           : $urandom_range(20, 60)) @(negedge clk_i);
      end
      m_axis_tready <= 1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    wait (idle_cycles >= 5000);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_word(logic action, logic [79:0] d, bit gaps);
    s_axis_tuser <= action;
    s_axis_tdata <= d;
    s_axis_tvalid <= 1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
    if (gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(0, 9) < 9 ? $urandom_range(1, 3) : $urandom_range(30, 80))
        @(negedge clk_i);
    end
  endtask

  task automatic write_texel(int x, int y, logic [31:0] v, bit gaps);
    logic [79:0] d;
    d = 80'({$urandom, $urandom, $urandom});
    d[40:35] = 6'(x); d[46:41] = 6'(y); d[78:47] = v; d[79] = 1'b0;
    written[y][x] = 1;
    send_word(1'b0, d, gaps);
  endtask

  task automatic sample(int cs, int ct, logic lod, bit gaps);
    logic [79:0] d;
    d = 80'({$urandom, $urandom, $urandom});
    d[16:0] = 17'(cs); d[33:17] = 17'(ct); d[34] = lod; d[79] = 1'b0;
    send_word(1'b1, d, gaps);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [7:0] v);
    cfg_index_i <= idx;
    cfg_data_i <= v;
    cfg_valid_i <= 1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 0;
    if (idx == RegWidthM1) cur_w = v[5:0];
    if (idx == RegHeightM1) cur_h = v[5:0];
  endtask

  task automatic random_cfg();
    set_reg(RegWrapS, 8'($urandom));
    set_reg(RegWrapT, 8'($urandom));
    set_reg(RegMinFilter, 8'($urandom));
    set_reg(RegMagFilter, 8'($urandom));
    set_reg(RegWidthM1, $urandom_range(0, 3) == 0 ? 8'd63 : 8'($urandom_range(0, 7)));
    set_reg(RegHeightM1, 8'($urandom_range(0, 7)));
  endtask

  // Sampling only reads within the current size; fill that region first so
  // no unwritten texel is ever read.
  task automatic fill_region(bit gaps);
    for (int y = 0; y <= cur_h; y++)
      for (int x = 0; x <= cur_w; x++)
        if (!written[y][x]) write_texel(x, y, $urandom, gaps);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 131071) - 65536;
      1: return $urandom_range(0, 8191) - 4096;
      2: return $urandom_range(0, 1) ? 65535 : -65536;
      default: return $urandom_range(0, 1023) - 512;
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: tiny texture, all wrap modes, both paths, coordinate extremes.
    set_reg(RegWidthM1, 8'd1);
    set_reg(RegHeightM1, 8'd1);
    write_texel(0, 0, 32'h0000_0000, 1'b0);
    write_texel(1, 0, 32'hffff_ffff, 1'b0);
    write_texel(0, 1, 32'h80ff_01a5, 1'b0);
    write_texel(63, 63, 32'h1234_5678, 1'b0);
    for (int m = 0; m < 4; m++) begin
      drain();
      set_reg(RegWrapS, 8'(m));
      set_reg(RegWrapT, 8'(3 - m));
      set_reg(RegMinFilter, m == 1 ? 8'd7 : 8'(5 - m));
      set_reg(RegMagFilter, 8'(m[0]));
      fill_region(1'b0);
      sample(-65536, 65535, 1'b0, 1'b0);
      sample(65535, -65536, 1'b1, 1'b0);
      sample(-1, -257, m[1], 1'b0);
      sample(128, 383, 1'b1, 1'b0);
      sample(-384, 0, 1'b0, 1'b0);
    end
    drain();
    set_reg(RegWidthM1, 8'd63);
    set_reg(RegHeightM1, 8'd3);
    fill_region(1'b0);
    sample(65535, 65535, 1'b1, 1'b0);
    sample(-65536, -65536, 1'b0, 1'b0);

    // Hold off the result side while samples pile up.
    drain();
    stall_hold = 1;
    for (int i = 0; i < 20; i++) sample(rand_coord(), rand_coord(), 1'($urandom), 1'b0);
    drain();

    while (sent < 1250) begin
      drain();
      random_cfg();
      fill_region(1'b1);
      for (int i = 0; i < 80; i++) begin
        if ($urandom_range(0, 4) == 0)
          write_texel($urandom_range(0, cur_w), $urandom_range(0, cur_h), $urandom, 1'b1);
        else
          sample(rand_coord(), rand_coord(), 1'($urandom), 1'b1);
      end
    end
    drain();
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

@@ texture_wrap_bilinear_sampler.f @@
sv/twbs_pkg.sv
sv/twbs_wrap.sv
sv/texture_wrap_bilinear_sampler.sv
tb/sv/twbs_checker.sv
tb/sv/tb.sv
